### hdl/blist_pkg.sv
`timescale 1ns / 1ps
package blist_pkg;

    localparam int ELEMENT_BITS = 32;
    localparam int CAPACITY     = 64;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_READ_IDX  = 3'd2,
        CMD_WRITE_IDX = 3'd3,
        CMD_REMOVE    = 3'd4,
        CMD_READ_LAST = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WS_PUSH,
        WS_INDEX,
        WS_SHIFT
    } t_wsel;

    typedef enum logic [1:0] {
        RS_INDEX,
        RS_LAST,
        RS_PTR
    } t_rsel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    mem_wr;
        t_wsel   wsel;
        logic    mem_rd;
        t_rsel   rsel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    pos_from_ptr;
        logic    pos_from_cnt;
        logic    data_en;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             idx_ok;
        logic             match;
        logic             ptr_last;
        logic             ptr_end;
    } t_dp_stat;

endpackage

### hdl/blist_ctrl.sv
`timescale 1ns / 1ps
module blist_ctrl import blist_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.cmd)
                    CMD_PUSH: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.mem_wr       = 1'b1;
                            o_cmd.wsel         = WS_PUSH;
                            o_cmd.cnt_inc      = 1'b1;
                            o_cmd.pos_from_cnt = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    CMD_READ_IDX: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.mem_rd = 1'b1;
                            o_cmd.rsel   = RS_INDEX;
                            n_state      = S_READ;
                        end else begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_BAD_INDEX;
                        end
                    end
                    CMD_WRITE_IDX: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.idx_ok) begin
                            o_cmd.mem_wr = 1'b1;
                            o_cmd.wsel   = WS_INDEX;
                        end else begin
                            o_cmd.status = ST_BAD_INDEX;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = S_SCAN_RD;
                        end
                    end
                    CMD_READ_LAST: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_BAD_INDEX;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            o_cmd.rsel   = RS_LAST;
                            n_state      = S_READ;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.finish  = 1'b1;
                o_cmd.data_en = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rsel   = RS_PTR;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    o_cmd.pos_from_ptr = 1'b1;
                    o_cmd.ptr_inc      = 1'b1;
                    n_state            = S_SHIFT_RD;
                end else if (i_stat.ptr_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.ptr_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rsel   = RS_PTR;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.wsel    = WS_SHIFT;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after finishing");

    a_capture_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (r_state == S_IDLE) && !o_cmd.finish)
        else $error("item captured outside idle");

    a_inc_with_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_inc |-> o_cmd.finish && o_cmd.mem_wr)
        else $error("count raised without a store write");
`endif

endmodule

### hdl/blist_dp.sv
`timescale 1ns / 1ps
module blist_dp import blist_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [CMD_W-1:0]    i_item_cmd,
    input  logic [INDEX_W-1:0]  i_item_index,
    input  logic [VALUE_W-1:0]  i_item_value,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data,
    output logic [POS_W-1:0]    o_position,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [ELEMENT_BITS-1:0] r_mem [CAPACITY];

    logic [CMD_W-1:0]        r_cmd;
    logic [INDEX_W-1:0]      r_index;
    logic [ELEMENT_BITS-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        r_ptr;
    logic [IDX_W-1:0]        r_pos;
    logic [ELEMENT_BITS-1:0] r_rdata;

    logic                    r_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [DATA_W-1:0]       r_data;
    logic [POS_W-1:0]        r_position;
    logic [COUNT_W-1:0]      r_out_count;

    logic [IDX_W-1:0]        wr_addr;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic [IDX_W-1:0]        rd_addr;

    always_comb begin
        case (i_cmd.wsel)
            WS_PUSH: begin
                wr_addr = IDX_W'(r_count);
                wr_data = r_value;
            end
            WS_INDEX: begin
                wr_addr = IDX_W'(r_index);
                wr_data = r_value;
            end
            WS_SHIFT: begin
                wr_addr = IDX_W'(r_ptr - 1'b1);
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = IDX_W'(r_index);
                wr_data = r_value;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.rsel)
            RS_INDEX: rd_addr = IDX_W'(r_index);
            RS_LAST:  rd_addr = IDX_W'(r_count - 1'b1);
            RS_PTR:   rd_addr = IDX_W'(r_ptr);
            default:  rd_addr = IDX_W'(r_index);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_item_cmd;
            r_index <= i_item_index;
            r_value <= ELEMENT_BITS'(i_item_value);
            r_pos   <= '0;
        end else if (i_cmd.pos_from_ptr) begin
            r_pos <= IDX_W'(r_ptr);
        end
        if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.finish) begin
            r_status    <= i_cmd.status;
            r_data      <= i_cmd.data_en ? DATA_W'(r_rdata) : '0;
            r_position  <= i_cmd.pos_from_cnt ? POS_W'(r_count) : POS_W'(r_pos);
            r_out_count <= COUNT_W'(n_count);
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(CAPACITY));
    assign o_stat.idx_ok   = (CMP_W'(r_index) < CMP_W'(r_count));
    assign o_stat.match    = (r_rdata == r_value);
    assign o_stat.ptr_last = ((CNT_W + 1)'(r_ptr) + 1'b1 >= (CNT_W + 1)'(r_count));
    assign o_stat.ptr_end  = (r_ptr == r_count);

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_position = r_position;
    assign o_count    = r_out_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_FULL)) |-> (r_out_count == COUNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.mem_wr && i_cmd.mem_rd))
        else $error("store read and written in the same cycle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> (r_count == $past(r_count)) || $past(i_cmd.cnt_dec))
        else $error("count changed outside a finishing step");
`endif

endmodule

### hdl/bounded_element_list_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// command   in         start && !busy       i_cmd, i_index, i_value
// result    out        o_done (one cycle)   o_status, o_data, o_position, o_count
//
// Push, pop, overwrite, bad index, empty and full cases: decided in the decode state, o_done registered.
// Read index and read last: add a read state (registered read of the element store).
// Remove value: a compare walk from the front, then a left shift of the later elements, empty if not found;
// one store port is shared by the compare walk and the left shift.
// Synchronous active-low reset clears the count to zero; no clearing pass on the store.
// busy goes high after accept and drops in the cycle o_done is shown; results cannot be stalled.
module bounded_element_list_top import blist_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data,
    output logic [POS_W-1:0]    o_position,
    output logic [COUNT_W-1:0]  o_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    blist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    blist_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_item_cmd   (i_cmd),
        .i_item_index (i_index),
        .i_item_value (i_value),
        .o_stat       (dp_stat),
        .o_valid      (o_done),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_position   (o_position),
        .o_count      (o_count)
    );

endmodule

### bench/bounded_element_list_top_tb.sv
`timescale 1ns / 1ps
module bounded_element_list_top_tb;
    import blist_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam int N_RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    class list_tracker;
        logic [ELEMENT_BITS-1:0] elems [CAPACITY];
        int unsigned             n_elems;
        t_list_result            pending_results[$];
        int                      mismatches;

        function new();
            n_elems    = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                   logic [VALUE_W-1:0] val);
            t_list_result            r;
            logic [ELEMENT_BITS-1:0] v;
            int                      hit;
            int                      i;
            r.status   = ST_OK;
            r.data     = '0;
            r.position = '0;
            v          = val[ELEMENT_BITS-1:0];
            case (cmd)
                CMD_PUSH: begin
                    if (n_elems >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        elems[IDX_W'(n_elems)] = v;
                        r.position             = POS_W'(n_elems);
                        n_elems++;
                    end
                end
                CMD_POP: begin
                    if (n_elems == 0) r.status = ST_EMPTY;
                    else n_elems--;
                end
                CMD_READ_IDX: begin
                    if (idx >= n_elems) r.status = ST_BAD_INDEX;
                    else r.data = DATA_W'(elems[IDX_W'(idx)]);
                end
                CMD_WRITE_IDX: begin
                    if (idx >= n_elems) r.status = ST_BAD_INDEX;
                    else elems[IDX_W'(idx)] = v;
                end
                CMD_REMOVE: begin
                    r.status = ST_EMPTY;
                    hit      = -1;
                    for (i = 0; i < n_elems; i++) begin
                        if (hit < 0 && elems[IDX_W'(i)] == v) hit = i;
                    end
                    if (hit >= 0) begin
                        for (i = hit; i + 1 < n_elems; i++)
                            elems[IDX_W'(i)] = elems[IDX_W'(i + 1)];
                        n_elems--;
                        r.position = POS_W'(hit);
                        r.status   = ST_OK;
                    end
                end
                CMD_READ_LAST: begin
                    if (n_elems == 0) r.status = ST_BAD_INDEX;
                    else r.data = DATA_W'(elems[IDX_W'(n_elems - 1)]);
                end
                default: ;
            endcase
            r.count = COUNT_W'(n_elems);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] dat,
                                   logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt);
            t_list_result e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result st=%0d data=%h pos=%0d cnt=%0d",
                             $realtime, st, dat, pos, cnt);
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status || dat !== e.data || pos !== e.position || cnt !== e.count)
            begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp st=%0d data=%h pos=%0d cnt=%0d",
                             $realtime, e.status, e.data, e.position, e.count);
                    $display("    got st=%0d data=%h pos=%0d cnt=%0d",
                             st, dat, pos, cnt);
                end
            end
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd   = '0;
    logic [INDEX_W-1:0] i_index = '0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_done;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]  o_data;
    logic [POS_W-1:0]   o_position;
    logic [COUNT_W-1:0] o_count;

    list_tracker tracker;
    int          cycle_cnt = 0;
    bit          no_gaps   = 0;

    bounded_element_list_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_index    (i_index),
        .i_value    (i_value),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_count    (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_status, o_data, o_position, o_count);
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // inputs change on the falling edge; accept is seen at the rising edge
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start   = 1'b0;
            i_cmd   = CMD_W'($urandom);
            i_index = INDEX_W'($urandom);
            i_value = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_cmd   = cmd;
        i_index = idx;
        i_value = val;
        do @(posedge i_clk); while (busy);
        tracker.note_command(cmd, idx, val);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(int mode);
        int thr [3][6] = '{'{55, 62, 72, 82, 88, 96},
                           '{10, 40, 50, 58, 85, 95},
                           '{25, 40, 55, 70, 82, 95}};
        int r;
        r = $urandom_range(0, 99);
        if (r < thr[mode][0]) return CMD_PUSH;
        if (r < thr[mode][1]) return CMD_POP;
        if (r < thr[mode][2]) return CMD_READ_IDX;
        if (r < thr[mode][3]) return CMD_WRITE_IDX;
        if (r < thr[mode][4]) return CMD_REMOVE;
        if (r < thr[mode][5]) return CMD_READ_LAST;
        return $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        int edges [4] = '{0, 63, 64, 255};
        r = $urandom_range(0, 9);
        if (r < 7 && tracker.n_elems > 0)
            return INDEX_W'($urandom_range(0, tracker.n_elems - 1));
        if (r == 7) return INDEX_W'(tracker.n_elems);
        if (r == 8) return INDEX_W'($urandom_range(0, 255));
        return INDEX_W'(edges[$urandom_range(0, 3)]);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(logic [CMD_W-1:0] cmd);
        int r;
        r = $urandom_range(0, 9);
        if (cmd == CMD_REMOVE && tracker.n_elems > 0 && r < 8)
            return VALUE_W'(tracker.elems[IDX_W'($urandom_range(0, tracker.n_elems - 1))]);
        if (r < 3) return $urandom_range(0, 7);
        if (r == 3) return '0;
        if (r == 4) return '1;
        return $urandom;
    endfunction

    initial begin
        int                 sent;
        int                 phase_len;
        int                 mode;
        int                 j;
        logic [CMD_W-1:0]   cmd;
        tracker = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list corners, reserved commands
        no_gaps = 1;
        send_item(CMD_READ_LAST, 8'd0, 32'h0);
        send_item(CMD_POP, 8'd0, 32'h0);
        send_item(CMD_REMOVE, 8'd0, 32'h0);
        send_item(CMD_READ_IDX, 8'd0, 32'h0);
        send_item(CMD_WRITE_IDX, 8'd0, 32'h5);
        send_item(CMD_RSVD6, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_RSVD7, 8'h00, 32'h0);
        // fill, duplicates, bad indexes
        send_item(CMD_PUSH, 8'd0, 32'h0);
        send_item(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_PUSH, 8'd0, 32'h5A5A_5A5A);
        send_item(CMD_PUSH, 8'd0, 32'hFFFF_FFFF);
        send_item(CMD_READ_IDX, 8'd0, 32'h0);
        send_item(CMD_READ_IDX, 8'd3, 32'h0);
        send_item(CMD_READ_IDX, 8'd4, 32'h0);
        send_item(CMD_READ_IDX, 8'hFF, 32'h0);
        send_item(CMD_WRITE_IDX, 8'hFF, 32'h1234_5678);
        send_item(CMD_WRITE_IDX, 8'd2, 32'hA5A5_A5A5);
        send_item(CMD_READ_LAST, 8'd0, 32'h0);
        // first match wins, later elements shift down
        send_item(CMD_REMOVE, 8'd0, 32'hFFFF_FFFF);
        send_item(CMD_REMOVE, 8'd0, 32'h1234_5678);
        send_item(CMD_READ_IDX, 8'd1, 32'h0);
        send_item(CMD_POP, 8'd0, 32'h0);
        send_item(CMD_READ_LAST, 8'd0, 32'h0);
        send_item(CMD_REMOVE, 8'd0, 32'h0);
        drain_results();

        sent = 0;
        mode = MODE_GROW;
        while (sent < N_RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 120);
            no_gaps   = ($urandom_range(0, 3) == 0);
            for (j = 0; j < phase_len && sent < N_RANDOM_ITEMS; j++) begin
                cmd = pick_cmd(mode);
                send_item(cmd, pick_index(), pick_value(cmd));
                sent++;
            end
            if ($urandom_range(0, 2) == 0) drain_results();
            if (tracker.n_elems >= CAPACITY - 4) mode = MODE_SHRINK;
            else if (tracker.n_elems <= 4) mode = MODE_GROW;
            else mode = $urandom_range(0, 2);
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
hdl/blist_pkg.sv
hdl/blist_ctrl.sv
hdl/blist_dp.sv
hdl/bounded_element_list_top.sv
bench/bounded_element_list_top_tb.sv
